// ===== sv/wds_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - shared definitions
// Operation and status codes, plus the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wds_pkg;

   // operation codes carried in the func field
   localparam logic [3:0] FN_CLEAR     = 4'd0;
   localparam logic [3:0] FN_ADD_VERT  = 4'd1;
   localparam logic [3:0] FN_ADD_ARC   = 4'd2;
   localparam logic [3:0] FN_RM_ARC    = 4'd3;
   localparam logic [3:0] FN_TEST_ARC  = 4'd4;
   localparam logic [3:0] FN_OUT_DEG   = 4'd5;
   localparam logic [3:0] FN_IN_DEG    = 4'd6;
   localparam logic [3:0] FN_RM_VERT   = 4'd7;
   localparam logic [3:0] FN_LIST      = 4'd8;
   localparam logic [3:0] FN_TRANSPOSE = 4'd9;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_DUP     = 3'd2;
   localparam logic [2:0] ST_MISSING = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // weight memory read address sources
   localparam logic [1:0] RD_AI  = 2'd0;
   localparam logic [1:0] RD_IJ  = 2'd1;
   localparam logic [1:0] RD_JI  = 2'd2;
   localparam logic [1:0] RD_SRC = 2'd3;

   // weight memory write address and data sources
   localparam logic [1:0] WR_IJ  = 2'd0;
   localparam logic [1:0] WR_JI  = 2'd1;
   localparam logic [1:0] WR_DST = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       commit;
      logic       acc_clr;
      logic       acc_add;
      logic       idx_clr;
      logic       idx_inc;
      logic       pair_init;
      logic       pair_step;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       hold_en;
      logic       list_emit;
   } cmd_type;

   typedef struct packed {
      logic [3:0] func;
      logic       a_ok;
      logic       two_plus;
      logic       out_free;
      logic       scan_end;
      logic       bit_now;
      logic       deg_zero;
      logic       list_last;
      logic       pair_end;
   } status_type;

endpackage

// ===== sv/wds_req_if.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface wds_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  func;
   logic [3:0]  first_vertex;
   logic [3:0]  second_vertex;
   logic [63:0] weight_in;

   modport source (output valid, func, first_vertex, second_vertex, weight_in,
                   input ready);
   modport sink   (input valid, func, first_vertex, second_vertex, weight_in,
                   output ready);
endinterface

// ===== sv/wds_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface wds_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        found;
   logic [4:0]  count_out;
   logic [3:0]  neighbour;
   logic [63:0] weight_out;
   logic        last;

   modport source (output valid, status, found, count_out, neighbour, weight_out,
                   last, input ready);
   modport sink   (input valid, status, found, count_out, neighbour, weight_out,
                   last, output ready);
endinterface

// ===== sv/wds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - controller
// Sequences each operation: dispatch, row scans, listing, weight swaps for
// transpose and weight compaction for vertex removal.
// ----------------------------------------------------------------------------
module wds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wds_pkg::status_type sts,
   output wds_pkg::cmd_type    cmd
);
   import wds_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_CNT   = 4'd2;
   localparam logic [3:0] S_LSCAN = 4'd3;
   localparam logic [3:0] S_LEMIT = 4'd4;
   localparam logic [3:0] S_TRA   = 4'd5;
   localparam logic [3:0] S_TRB   = 4'd6;
   localparam logic [3:0] S_TWA   = 4'd7;
   localparam logic [3:0] S_TWB   = 4'd8;
   localparam logic [3:0] S_CRD   = 4'd9;
   localparam logic [3:0] S_CWR   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.func) inside
               FN_OUT_DEG, FN_IN_DEG, FN_LIST: begin
                  if (sts.a_ok) begin
                     cmd.acc_clr = 1'b1;
                     state_in    = S_CNT;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               FN_RM_VERT: begin
                  if (sts.a_ok && sts.two_plus) begin
                     cmd.pair_init = 1'b1;
                     state_in      = S_CRD;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               FN_TRANSPOSE: begin
                  if (sts.two_plus) begin
                     cmd.pair_init = 1'b1;
                     state_in      = S_TRA;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_CNT: begin
            cmd.acc_add = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.scan_end) begin
               if (sts.func == FN_LIST) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_LSCAN;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_LSCAN: begin
            if (sts.deg_zero) begin
               state_in = S_FIN;
            end else if (sts.bit_now) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_AI;
               state_in   = S_LEMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_LEMIT: begin
            if (sts.out_free) begin
               cmd.list_emit = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = sts.list_last ? S_IDLE : S_LSCAN;
            end
         end
         S_TRA: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IJ;
            state_in   = S_TRB;
         end
         S_TRB: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_JI;
            cmd.hold_en = 1'b1;
            state_in    = S_TWA;
         end
         S_TWA: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IJ;
            state_in   = S_TWB;
         end
         S_TWB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_JI;
            if (sts.pair_end) begin
               state_in = S_FIN;
            end else begin
               cmd.pair_step = 1'b1;
               state_in      = S_TRA;
            end
         end
         S_CRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SRC;
            state_in   = S_CWR;
         end
         S_CWR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DST;
            if (sts.pair_end) begin
               state_in = S_FIN;
            end else begin
               cmd.pair_step = 1'b1;
               state_in      = S_CRD;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/wds_dpath.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - datapath
// Adjacency matrix, vertex count, weight memory, scan counters and the
// result register.
// ----------------------------------------------------------------------------
module wds_dpath #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [4:0]          csr_write_data,
   input  logic [3:0]          req_func,
   input  logic [3:0]          req_first_vertex,
   input  logic [3:0]          req_second_vertex,
   input  logic [63:0]         req_weight_in,
   input  wds_pkg::cmd_type    cmd,
   output wds_pkg::status_type sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_found,
   output logic [4:0]          rsp_count_out,
   output logic [3:0]          rsp_neighbour,
   output logic [63:0]         rsp_weight_out,
   output logic                rsp_last
);
   import wds_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);

   typedef logic [MAX_VERTICES-1:0] row_type;

   logic [4:0]    start_ff, start_in;
   logic [CW-1:0] count_ff, count_in;
   row_type       rows_ff [MAX_VERTICES];
   row_type       rows_in [MAX_VERTICES];
   row_type       drop_rows [MAX_VERTICES];
   row_type       trn_rows [MAX_VERTICES];

   logic [3:0]    func_ff, func_in;
   logic [3:0]    a_ff, a_in;
   logic [3:0]    b_ff, b_in;
   logic [63:0]   w_ff, w_in;

   logic [VW-1:0] i_ff, i_in;
   logic [VW-1:0] j_ff, j_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic [CW-1:0] emit_ff, emit_in;

   logic [63:0]   weight_mem [DEPTH];
   logic [63:0]   rdata_ff;
   logic [63:0]   hold_ff, hold_in;

   logic          valid_ff, valid_in;
   logic [2:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [3:0]    nb_ff, nb_in;
   logic [63:0]   wout_ff, wout_in;
   logic          last_ff, last_in;

   logic [31:0]   n_w, a_w, b_w, i_w, j_w;
   logic [VW-1:0] a_idx, b_idx;
   logic          a_ok, b_ok, full, arc_ab, j_last, is_trn;
   logic [CW-1:0] sat_start;
   logic [31:0]   oi_w, oj_w;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [63:0]   wr_data;
   logic          wr_go, add_arc_go;

   assign n_w    = 32'(count_ff);
   assign a_w    = 32'(a_ff);
   assign b_w    = 32'(b_ff);
   assign i_w    = 32'(i_ff);
   assign j_w    = 32'(j_ff);
   assign a_idx  = VW'(a_ff);
   assign b_idx  = VW'(b_ff);
   assign a_ok   = a_w < n_w;
   assign b_ok   = b_w < n_w;
   assign full   = n_w >= 32'(MAX_VERTICES);
   assign arc_ab = a_ok && b_ok && rows_ff[a_idx][b_idx];
   assign is_trn = func_ff == FN_TRANSPOSE;
   assign sat_start = (32'(start_ff) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(start_ff);

   // transpose walks j = i+1 .. n-1; compaction walks j = 0 .. n-2
   assign j_last = is_trn ? (j_w == n_w - 32'd1) : (j_w == n_w - 32'd2);

   always_comb begin
      sts           = '0;
      sts.func      = func_ff;
      sts.a_ok      = a_ok;
      sts.two_plus  = n_w >= 32'd2;
      sts.out_free  = !valid_ff || rsp_ready;
      sts.scan_end  = i_w == n_w - 32'd1;
      sts.bit_now   = (func_ff == FN_IN_DEG) ? rows_ff[i_ff][a_idx] : rows_ff[a_idx][i_ff];
      sts.deg_zero  = acc_ff == '0;
      sts.list_last = 32'(emit_ff) + 32'd1 == 32'(acc_ff);
      sts.pair_end  = (i_w == n_w - 32'd2) && j_last;
   end

   // matrix with one vertex taken out, higher vertices renumbered down
   always_comb begin
      row_type src_row;
      int      nxt;
      for (int r = 0; r < MAX_VERTICES; r++) begin
         nxt = (r + 1 < MAX_VERTICES) ? r + 1 : r;
         if (r < a_w) begin
            src_row = rows_ff[r];
         end else if (r + 1 < MAX_VERTICES) begin
            src_row = rows_ff[nxt];
         end else begin
            src_row = '0;
         end
         for (int c = 0; c < MAX_VERTICES; c++) begin
            if (c < a_w) begin
               drop_rows[r][c] = src_row[c];
            end else if (c + 1 < MAX_VERTICES) begin
               drop_rows[r][c] = src_row[(c + 1 < MAX_VERTICES) ? c + 1 : c];
            end else begin
               drop_rows[r][c] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
         for (int c = 0; c < MAX_VERTICES; c++) begin
            trn_rows[r][c] = rows_ff[c][r];
         end
      end
   end

   // start count write, and graph state update on commit
   always_comb begin
      start_in = csr_write_en ? csr_write_data : start_ff;
      count_in = count_ff;
      rows_in  = rows_ff;
      if (cmd.commit) begin
         case (func_ff)
            FN_CLEAR: begin
               count_in = sat_start;
               for (int r = 0; r < MAX_VERTICES; r++) begin
                  rows_in[r] = '0;
               end
            end
            FN_ADD_VERT: begin
               if (!full) begin
                  rows_in[VW'(count_ff)] = '0;
                  count_in = count_ff + CW'(1);
               end
            end
            FN_ADD_ARC: begin
               if (a_ok && b_ok && !arc_ab) begin
                  rows_in[a_idx][b_idx] = 1'b1;
               end
            end
            FN_RM_ARC: begin
               if (arc_ab) begin
                  rows_in[a_idx][b_idx] = 1'b0;
               end
            end
            FN_RM_VERT: begin
               if (a_ok) begin
                  rows_in  = drop_rows;
                  count_in = count_ff - CW'(1);
               end
            end
            FN_TRANSPOSE: rows_in = trn_rows;
            default: ;
         endcase
      end
   end

   // request latch and scan counters
   always_comb begin
      func_in = func_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      w_in    = w_ff;
      if (cmd.load_req) begin
         func_in = req_func;
         a_in    = req_first_vertex;
         b_in    = req_second_vertex;
         w_in    = req_weight_in;
      end

      acc_in  = acc_ff;
      emit_in = emit_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (cmd.acc_clr) begin
         acc_in  = '0;
         emit_in = '0;
         i_in    = '0;
      end else begin
         if (cmd.acc_add) begin
            acc_in = acc_ff + CW'(sts.bit_now);
         end
         if (cmd.list_emit) begin
            emit_in = emit_ff + CW'(1);
         end
         if (cmd.idx_clr || cmd.pair_init) begin
            i_in = '0;
         end else if (cmd.idx_inc || (cmd.pair_step && j_last)) begin
            i_in = i_ff + VW'(1);
         end
      end
      if (cmd.pair_init) begin
         j_in = is_trn ? VW'(1) : '0;
      end else if (cmd.pair_step) begin
         if (j_last) begin
            j_in = is_trn ? VW'(i_w + 32'd2) : '0;
         end else begin
            j_in = j_ff + VW'(1);
         end
      end
   end

   // weight memory addressing
   assign oi_w = (i_w < a_w) ? i_w : i_w + 32'd1;
   assign oj_w = (j_w < a_w) ? j_w : j_w + 32'd1;

   always_comb begin
      case (cmd.rd_sel)
         RD_AI:   rd_addr = AW'(a_w * 32'(MAX_VERTICES) + i_w);
         RD_IJ:   rd_addr = AW'(i_w * 32'(MAX_VERTICES) + j_w);
         RD_JI:   rd_addr = AW'(j_w * 32'(MAX_VERTICES) + i_w);
         default: rd_addr = AW'(oi_w * 32'(MAX_VERTICES) + oj_w);
      endcase
   end

   assign add_arc_go = cmd.commit && (func_ff == FN_ADD_ARC) && a_ok && b_ok && !arc_ab;
   assign wr_go      = add_arc_go || cmd.wr_en;

   always_comb begin
      if (add_arc_go) begin
         wr_addr = AW'(a_w * 32'(MAX_VERTICES) + b_w);
         wr_data = w_ff;
      end else begin
         case (cmd.wr_sel)
            WR_JI: begin
               wr_addr = AW'(j_w * 32'(MAX_VERTICES) + i_w);
               wr_data = hold_ff;
            end
            default: begin
               wr_addr = AW'(i_w * 32'(MAX_VERTICES) + j_w);
               wr_data = rdata_ff;
            end
         endcase
      end
   end

   assign hold_in = cmd.hold_en ? rdata_ff : hold_ff;

   always_ff @(posedge clock) begin
      if (wr_go) begin
         weight_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= weight_mem[rd_addr];
      end
   end

   // result register
   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      status_in = status_ff;
      found_in  = found_ff;
      cnt_in    = cnt_ff;
      nb_in     = nb_ff;
      wout_in   = wout_ff;
      last_in   = last_ff;
      if (cmd.list_emit) begin
         valid_in  = 1'b1;
         status_in = ST_OK;
         found_in  = 1'b0;
         cnt_in    = 5'(acc_ff);
         nb_in     = 4'(i_ff);
         wout_in   = rdata_ff;
         last_in   = sts.list_last;
      end else if (cmd.commit) begin
         valid_in  = 1'b1;
         status_in = ST_OK;
         found_in  = 1'b0;
         cnt_in    = '0;
         nb_in     = '0;
         wout_in   = '0;
         last_in   = 1'b1;
         case (func_ff) inside
            FN_CLEAR: cnt_in = 5'(sat_start);
            FN_ADD_VERT: begin
               if (full) begin
                  status_in = ST_FULL;
                  cnt_in    = 5'(count_ff);
               end else begin
                  cnt_in = 5'(n_w + 32'd1);
               end
            end
            FN_ADD_ARC: begin
               if (!a_ok || !b_ok) begin
                  status_in = ST_INVALID;
               end else if (arc_ab) begin
                  status_in = ST_DUP;
               end
            end
            FN_RM_ARC: begin
               if (!a_ok) begin
                  status_in = ST_INVALID;
               end else if (!arc_ab) begin
                  status_in = ST_MISSING;
               end
            end
            FN_TEST_ARC: begin
               if (!a_ok || !b_ok) begin
                  status_in = ST_INVALID;
               end else begin
                  found_in = arc_ab;
               end
            end
            FN_OUT_DEG, FN_IN_DEG: begin
               if (!a_ok) begin
                  status_in = ST_INVALID;
               end else begin
                  cnt_in = 5'(acc_ff);
               end
            end
            FN_RM_VERT: begin
               if (!a_ok) begin
                  status_in = ST_INVALID;
                  cnt_in    = 5'(count_ff);
               end else begin
                  cnt_in = 5'(n_w - 32'd1);
               end
            end
            FN_LIST: begin
               if (!a_ok) begin
                  status_in = ST_INVALID;
               end
            end
            FN_TRANSPOSE: ;
            default: cnt_in = 5'(count_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         for (int r = 0; r < MAX_VERTICES; r++) begin
            rows_ff[r] <= '0;
         end
      end else begin
         start_ff <= start_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         rows_ff  <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      w_ff      <= w_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      emit_ff   <= emit_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      cnt_ff    <= cnt_in;
      nb_ff     <= nb_in;
      wout_ff   <= wout_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_count_out  = cnt_ff;
   assign rsp_neighbour  = nb_ff;
   assign rsp_weight_out = wout_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== sv/weighted_digraph_store.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - top level
// Directed weighted graph held as an adjacency bit matrix and a weight memory.
// ----------------------------------------------------------------------------
// Each request word runs one graph operation and answers with one response
// word, or for a listing with one word per neighbour in ascending vertex
// order, the final word marked by last. One operation runs at a time; a new
// request is taken as soon as the previous one has handed its final word to
// the response register, even while that word still waits. Degree queries
// count one matrix bit per cycle. A listing first counts the row, then scans
// its bits and reads the weight memory once per neighbour. Transpose swaps
// the weights of each vertex pair with two reads and two writes, and vertex
// removal moves each kept weight with one read and one write, both set by the
// single read and single write port of the weight memory. The weight memory
// needs no clearing pass: only weights of arcs are listed, and each was
// written when its arc was added.
// ----------------------------------------------------------------------------
module weighted_digraph_store #(
   parameter int MAX_VERTICES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [4:0] csr_write_data,
   wds_req_if.sink    req_ch,
   wds_rsp_if.source  rsp_ch
);
   import wds_pkg::*;

   // command and status words between the sequencer and the datapath
   cmd_type    cmd;
   status_type sts;

   // controller: hold ready high only while no operation is in flight
   wds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: matrix, weights, counters and the response register
   wds_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_func          (req_ch.func),
      .req_first_vertex  (req_ch.first_vertex),
      .req_second_vertex (req_ch.second_vertex),
      .req_weight_in     (req_ch.weight_in),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_found         (rsp_ch.found),
      .rsp_count_out     (rsp_ch.count_out),
      .rsp_neighbour     (rsp_ch.neighbour),
      .rsp_weight_out    (rsp_ch.weight_out),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// ===== sv/wds_checker.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - port checker
// Watches the response channel for consistency of the result words.
// ----------------------------------------------------------------------------
module wds_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_found,
   input logic [63:0] rsp_weight_out,
   input logic        rsp_last
);
   import wds_pkg::*;

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight_out)
                                  && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response word changed");

   // only listing words may be non-final, and those are always ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK)
      else $error("non-final response word with error status");

   // an error ends the operation
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error status on a non-final word");

   // an arc found is a successful single-word test
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK && rsp_last
                                 && rsp_weight_out == 64'd0)
      else $error("found flag on an unexpected word");

endmodule

bind weighted_digraph_store wds_port_checker u_wds_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_found      (rsp_ch.found),
   .rsp_weight_out (rsp_ch.weight_out),
   .rsp_last       (rsp_ch.last)
);

// ===== tb/wds_tb_if.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store testbench - channel check helpers
// Shared word types for the scoreboard side of the testbench.
// ----------------------------------------------------------------------------
package wds_tb_pkg;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [4:0]  count_out;
      logic [3:0]  neighbour;
      logic [63:0] weight_out;
      logic        last;
   } rsp_word_type;

endpackage

// ===== tb/wds_checker.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - scoreboard
// Watches both channels, keeps a shadow graph and compares every response.
// ----------------------------------------------------------------------------
module wds_checker
   import wds_pkg::*;
   import wds_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [4:0] csr_write_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [3:0] req_func,
   input  logic [3:0] req_first,
   input  logic [3:0] req_second,
   input  logic [63:0] req_weight,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_word_type rsp_word,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = 16;

   logic [4:0]  start_n;
   logic [4:0]  vert_n;
   logic [15:0] rows [NV];
   logic [63:0] weights [NV][NV];
   rsp_word_type expected_words [$];

   assign pending = expected_words.size();

   function automatic rsp_word_type mk(logic [2:0] st, logic fd, logic [4:0] cnt,
                                       logic [3:0] nb, logic [63:0] w, logic lst);
      rsp_word_type r;
      r = '{st, fd, cnt, nb, w, lst};
      return r;
   endfunction

   function automatic logic [4:0] ones(logic [15:0] x);
      logic [4:0] c;
      c = 0;
      for (int i = 0; i < NV; i++) c += x[i];
      return c;
   endfunction

   // update the shadow graph and queue the words this operation should yield
   task automatic run_graph_op(logic [3:0] fn, logic [3:0] a, logic [3:0] b,
                               logic [63:0] w);
      logic a_ok, b_ok;
      logic [15:0] row, t;
      logic [4:0] c;
      int k;
      a_ok = a < vert_n;
      b_ok = b < vert_n;
      case (fn)
         FN_CLEAR: begin
            vert_n = (start_n > NV) ? 5'(NV) : start_n;
            foreach (rows[i]) rows[i] = '0;
            expected_words.push_back(mk(ST_OK, 0, vert_n, 0, 0, 1));
         end
         FN_ADD_VERT: begin
            if (vert_n >= NV) begin
               expected_words.push_back(mk(ST_FULL, 0, vert_n, 0, 0, 1));
            end else begin
               rows[vert_n] = '0;
               vert_n++;
               expected_words.push_back(mk(ST_OK, 0, vert_n, 0, 0, 1));
            end
         end
         FN_ADD_ARC: begin
            if (!a_ok || !b_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else if (rows[a][b]) expected_words.push_back(mk(ST_DUP, 0, 0, 0, 0, 1));
            else begin
               rows[a][b] = 1'b1;
               weights[a][b] = w;
               expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
            end
         end
         FN_RM_ARC: begin
            if (!a_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else if (!b_ok || !rows[a][b])
               expected_words.push_back(mk(ST_MISSING, 0, 0, 0, 0, 1));
            else begin
               rows[a][b] = 1'b0;
               expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
            end
         end
         FN_TEST_ARC: begin
            if (!a_ok || !b_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else expected_words.push_back(mk(ST_OK, rows[a][b], 0, 0, 0, 1));
         end
         FN_OUT_DEG: begin
            if (!a_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else expected_words.push_back(mk(ST_OK, 0, ones(rows[a]), 0, 0, 1));
         end
         FN_IN_DEG: begin
            if (!a_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else begin
               c = 0;
               for (int i = 0; i < vert_n; i++) c += rows[i][a];
               expected_words.push_back(mk(ST_OK, 0, c, 0, 0, 1));
            end
         end
         FN_RM_VERT: begin
            if (!a_ok) expected_words.push_back(mk(ST_INVALID, 0, vert_n, 0, 0, 1));
            else begin
               // shift rows up, squeeze the column out, renumber weights
               for (int i = a; i + 1 < vert_n; i++) rows[i] = rows[i+1];
               rows[vert_n-1] = '0;
               for (int i = 0; i + 1 < vert_n; i++) begin
                  t = rows[i];
                  row = '0;
                  for (int j = 0; j < NV; j++)
                     if (j < a) row[j] = t[j];
                     else if (j + 1 < NV) row[j] = t[j+1];
                  rows[i] = row;
               end
               for (int i = 0; i + 1 < vert_n; i++)
                  for (int j = 0; j + 1 < vert_n; j++)
                     weights[i][j] = weights[(i < a) ? i : i+1][(j < a) ? j : j+1];
               vert_n--;
               expected_words.push_back(mk(ST_OK, 0, vert_n, 0, 0, 1));
            end
         end
         FN_LIST: begin
            if (!a_ok) expected_words.push_back(mk(ST_INVALID, 0, 0, 0, 0, 1));
            else begin
               row = rows[a];
               for (int i = vert_n; i < NV; i++) row[i] = 1'b0;
               c = ones(row);
               if (row == 0) expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
               else begin
                  k = 0;
                  for (int i = 0; i < NV; i++)
                     if (row[i]) begin
                        k++;
                        expected_words.push_back(mk(ST_OK, 0, c, 4'(i),
                                                    weights[a][i], k == c));
                     end
               end
            end
         end
         FN_TRANSPOSE: begin
            logic ij, ji;
            logic [63:0] tw;
            for (int i = 0; i < vert_n; i++)
               for (int j = i + 1; j < vert_n; j++) begin
                  ij = rows[i][j];
                  ji = rows[j][i];
                  tw = weights[i][j];
                  weights[i][j] = weights[j][i];
                  weights[j][i] = tw;
                  rows[i][j] = ji;
                  rows[j][i] = ij;
               end
            expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
         end
         default: expected_words.push_back(mk(ST_OK, 0, vert_n, 0, 0, 1));
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         start_n = 0;
         vert_n = 0;
         foreach (rows[i]) rows[i] = '0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) start_n = csr_write_data;
         if (req_valid && req_ready) run_graph_op(req_func, req_first, req_second, req_weight);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_word);
               fail_count++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_word !== exp_w) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_w, rsp_word);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph store - testbench top
// Drives directed and random graph operations through the request channel,
// varies back-pressure on both sides and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module testbench;
   import wds_pkg::*;
   import wds_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [4:0] csr_write_data = 0;
   int   fail_count, pending;
   int   send_idle = 0, recv_idle = 0;   // percent idle per side
   logic hold_req = 0;                   // asks for one long receiver stall
   logic hold_rsp = 0;                   // receiver held off while set
   logic [4:0] shadow_n = 0;             // own view of vertex count for steering

   wds_req_if req_ch ();
   wds_rsp_if rsp_ch ();
   rsp_word_type rsp_word;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   weighted_digraph_store u_top (
      .clock, .reset, .csr_write_en, .csr_write_data,
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   assign rsp_word = '{rsp_ch.status, rsp_ch.found, rsp_ch.count_out,
                       rsp_ch.neighbour, rsp_ch.weight_out, rsp_ch.last};

   wds_checker u_checker (
      .clock, .reset, .csr_write_en, .csr_write_data,
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_func(req_ch.func),
      .req_first(req_ch.first_vertex), .req_second(req_ch.second_vertex),
      .req_weight(req_ch.weight_in),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_word,
      .fail_count, .pending
   );

   // receiver: stall at random, or hold off entirely while hold_rsp is set
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // long receiver stall, counted here while the sender keeps offering words
   initial begin
      @(posedge hold_req);
      hold_rsp <= 1'b1;
      repeat (400) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // offer one word, idling first at random; hold it until accepted
   task automatic send_word(logic [3:0] fn, logic [3:0] a, logic [3:0] b, logic [63:0] w);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= fn;
      req_ch.first_vertex <= a;
      req_ch.second_vertex <= b;
      req_ch.weight_in <= w;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      // keep our own vertex count so random indices mostly land in range
      case (fn)
         FN_CLEAR:    shadow_n = (csr_write_data > 16) ? 5'd16 : csr_write_data;
         FN_ADD_VERT: if (shadow_n < 16) shadow_n++;
         FN_RM_VERT:  if (a < shadow_n) shadow_n--;
         default: ;
      endcase
   endtask

   task automatic drop_valid();
      req_ch.valid <= 1'b0;
   endtask

   // drain every expected word, then give the block time to settle
   task automatic wait_idle();
      drop_valid();
      while (pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_start_count(logic [4:0] v);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [3:0] pick_vertex();
      // mostly valid indices, sometimes anything
      if (shadow_n != 0 && $urandom_range(9) != 0) return 4'($urandom_range(shadow_n - 1));
      return 4'($urandom_range(15));
   endfunction

   function automatic logic [63:0] rand_weight();
      return {$urandom, $urandom};
   endfunction

   // one random operation weighted towards arc building and listing
   task automatic send_random_op();
      int r;
      logic [3:0] fn;
      r = $urandom_range(99);
      if (r < 30) fn = FN_ADD_ARC;
      else if (r < 38) fn = FN_RM_ARC;
      else if (r < 46) fn = FN_TEST_ARC;
      else if (r < 53) fn = FN_OUT_DEG;
      else if (r < 60) fn = FN_IN_DEG;
      else if (r < 72) fn = FN_LIST;
      else if (r < 78) fn = FN_TRANSPOSE;
      else if (r < 84) fn = FN_ADD_VERT;
      else if (r < 90) fn = FN_RM_VERT;
      else if (r < 93) fn = FN_CLEAR;
      else fn = 4'($urandom_range(15));
      send_word(fn, pick_vertex(), pick_vertex(), rand_weight());
   endtask

   initial begin
      req_ch.valid = 0;
      req_ch.func = FN_CLEAR;
      req_ch.first_vertex = 0;
      req_ch.second_vertex = 0;
      req_ch.weight_in = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty graph, invalid indices, full graph, duplicates, listing
      send_word(FN_OUT_DEG, 0, 0, 0);
      send_word(FN_ADD_VERT, 0, 0, 0);
      send_word(FN_ADD_VERT, 0, 0, 0);
      send_word(FN_ADD_ARC, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(FN_ADD_ARC, 0, 1, 64'h0);
      send_word(FN_ADD_ARC, 0, 0, 64'h8000_0000_0000_0001);
      send_word(FN_ADD_ARC, 1, 15, 64'h1);
      send_word(FN_RM_ARC, 1, 15, 0);
      send_word(FN_RM_ARC, 1, 0, 0);
      send_word(FN_TEST_ARC, 0, 1, 0);
      send_word(FN_TEST_ARC, 15, 0, 0);
      send_word(FN_LIST, 0, 0, 0);
      send_word(FN_LIST, 1, 0, 0);
      send_word(FN_LIST, 9, 0, 0);
      send_word(FN_IN_DEG, 1, 0, 0);
      send_word(FN_TRANSPOSE, 0, 0, 0);
      send_word(FN_LIST, 1, 0, 0);
      send_word(FN_RM_VERT, 0, 0, 0);
      send_word(FN_RM_VERT, 7, 0, 0);
      send_word(4'd12, 0, 0, 0);
      send_word(4'd15, 4'hF, 4'hF, 0);
      wait_idle();
      write_start_count(5'd31);           // above capacity, saturates on clear
      send_word(FN_CLEAR, 0, 0, 0);
      send_word(FN_ADD_VERT, 0, 0, 0);    // full
      for (int j = 0; j < 16; j++) send_word(FN_ADD_ARC, 15, 4'(j), rand_weight());
      send_word(FN_LIST, 15, 0, 0);
      send_word(FN_RM_VERT, 15, 0, 0);

      // random phases: each with its own start count and idling mix
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: write_start_count(5'd0);
            1: write_start_count(5'd16);
            2: write_start_count(5'd4);
            3: write_start_count(5'd20);
            default: write_start_count(5'($urandom_range(16)));
         endcase
         send_idle = (ph < 2) ? 34 : (ph < 4) ? 70 : 0;
         recv_idle = (ph < 2) ? 70 : (ph < 4) ? 34 : 0;
         send_word(FN_CLEAR, 0, 0, 0);
         if (ph == 4) hold_req <= 1'b1;   // receiver stalls while requests pile up
         for (int n = 0; n < 56; n++) send_random_op();
      end
      wait_idle();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ===== weighted_digraph_store.f =====
sv/wds_pkg.sv
sv/wds_req_if.sv
sv/wds_rsp_if.sv
sv/wds_ctrl.sv
sv/wds_dpath.sv
sv/weighted_digraph_store.sv
sv/wds_checker.sv
tb/wds_tb_if.sv
tb/wds_checker.sv
tb/testbench.sv
